[rtl/i2cbr_pkg.sv]
// Shared types, codes and constants for the I2C bus recovery supervisor.
package i2cbr_pkg;

   localparam int TIME_WIDTH     = 32;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int BACKOFF_WIDTH  = 17;

   // event kinds
   localparam logic [1:0] FUNC_FAILURE = 2'd0;
   localparam logic [1:0] FUNC_SUCCESS = 2'd1;
   localparam logic [1:0] FUNC_RETRY   = 2'd2;

   // transfer error codes that are NACKs
   localparam logic [2:0] ERR_NACK_ADDR = 3'd2;
   localparam logic [2:0] ERR_NACK_DATA = 3'd3;

   // notice codes
   localparam logic [2:0] NOTICE_NONE          = 3'd0;
   localparam logic [2:0] NOTICE_RECOVERED     = 3'd1;
   localparam logic [2:0] NOTICE_HELD_LOW      = 3'd2;
   localparam logic [2:0] NOTICE_GAVE_UP       = 3'd3;
   localparam logic [2:0] NOTICE_HELD_GAVE_UP  = 3'd4;
   localparam logic [2:0] NOTICE_BACK          = 3'd5;

   // register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_STREAK_THRESHOLD = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_MIN_INTERVAL     = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_MAX_INTERVAL     = 2'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_GIVE_UP_AFTER    = 2'd3;

   // register reset values
   localparam logic [7:0]  RST_STREAK_THRESHOLD = 8'd3;
   localparam logic [15:0] RST_MIN_INTERVAL     = 16'd250;
   localparam logic [15:0] RST_MAX_INTERVAL     = 16'd8000;
   localparam logic [7:0]  RST_GIVE_UP_AFTER    = 8'd5;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef struct packed {
      logic [7:0]  streak_threshold;
      logic [15:0] min_interval_ms;
      logic [15:0] max_interval_ms;
      logic [7:0]  give_up_after;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            func;
      logic [2:0]            error_code;
      logic                  lines_high;
      logic [TIME_WIDTH-1:0] now_ms;
      logic                  clear_released;
   } evt_type;

   typedef struct packed {
      logic       recovery_fired;
      logic       bus_down;
      logic [2:0] last_error;
      logic [2:0] notice;
   } rsp_type;

endpackage

[rtl/i2c_bus_recovery_supervisor_core.sv]
// Top level of the I2C bus recovery supervisor: input stage, evaluation, result stage.
//
//   channel   direction  handshake                       payload
//   req_      in         req_valid / req_ready           func, error_code, lines_high,
//                                                        now_ms, clear_released
//   rsp_      out        rsp_valid / rsp_ready           recovery_fired, bus_down,
//                                                        last_error, notice
//   csr_      in         csr_wr_en (no wait)             csr_addr, csr_wr_data
//
// One event per cycle while the result side is not stalled; an accepted event passes
// through the input register, then the result register, before its result appears.
// The recovery state updates as an event moves into the result register, so the
// next event sees it at once.
// A stalled result holds the result register; the input register still takes a
// beat while it is empty or when it empties into a free result register.
// Synchronous reset clears the valid flags and recovery state and loads register defaults.
module i2c_bus_recovery_supervisor_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic [2:0]                           req_error_code,
   input  logic                                 req_lines_high,
   input  logic [i2cbr_pkg::TIME_WIDTH-1:0]     req_now_ms,
   input  logic                                 req_clear_released,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_recovery_fired,
   output logic                                 rsp_bus_down,
   output logic [2:0]                           rsp_last_error,
   output logic [2:0]                           rsp_notice,
   input  logic                                 csr_wr_en,
   input  logic [i2cbr_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [i2cbr_pkg::CSR_DATA_WIDTH-1:0] csr_wr_data
);
   import i2cbr_pkg::*;

   cfg_type cfg;
   evt_type in_evt_ff, in_evt_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_rsp_ff, eval_rsp;
   logic    out_valid_ff, out_valid_in;
   logic    advance;
   logic    req_beat;

   i2cbr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   i2cbr_eval u_eval (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .evt     (in_evt_ff),
      .cfg     (cfg),
      .rsp     (eval_rsp)
   );

   // move the held event on whenever the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_beat  = req_valid && req_ready;

   always_comb begin
      in_evt_in.func           = req_func;
      in_evt_in.error_code     = req_error_code;
      in_evt_in.lines_high     = req_lines_high;
      in_evt_in.now_ms         = req_now_ms;
      in_evt_in.clear_released = req_clear_released;
      in_valid_in  = req_beat || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_evt_ff <= in_evt_in;
      end
      if (advance) begin
         out_rsp_ff <= eval_rsp;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_recovery_fired = out_rsp_ff.recovery_fired;
   assign rsp_bus_down       = out_rsp_ff.bus_down;
   assign rsp_last_error     = out_rsp_ff.last_error;
   assign rsp_notice         = out_rsp_ff.notice;

endmodule

[rtl/i2cbr_csr.sv]
// Configuration registers of the recovery supervisor.
module i2cbr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [i2cbr_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [i2cbr_pkg::CSR_DATA_WIDTH-1:0] csr_wr_data,
   output i2cbr_pkg::cfg_type                   cfg
);
   import i2cbr_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.streak_threshold <= RST_STREAK_THRESHOLD;
         cfg_ff.min_interval_ms  <= RST_MIN_INTERVAL;
         cfg_ff.max_interval_ms  <= RST_MAX_INTERVAL;
         cfg_ff.give_up_after    <= RST_GIVE_UP_AFTER;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_STREAK_THRESHOLD: cfg_ff.streak_threshold <= csr_wr_data[7:0];
            CSR_MIN_INTERVAL:     cfg_ff.min_interval_ms  <= csr_wr_data;
            CSR_MAX_INTERVAL:     cfg_ff.max_interval_ms  <= csr_wr_data;
            CSR_GIVE_UP_AFTER:    cfg_ff.give_up_after    <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/i2cbr_eval.sv]
// Recovery state and the single-pass event evaluation.
module i2cbr_eval (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  i2cbr_pkg::evt_type evt,
   input  i2cbr_pkg::cfg_type cfg,
   output i2cbr_pkg::rsp_type rsp
);
   import i2cbr_pkg::*;

   logic [7:0]               streak_ff, streak_in;
   logic [2:0]               last_err_ff, last_err_in;
   logic [TIME_WIDTH-1:0]    window_ff, window_in;
   logic [BACKOFF_WIDTH-1:0] backoff_ff, backoff_in;
   logic [7:0]               failed_ff, failed_in;
   logic                     given_up_ff, given_up_in;
   logic                     rep_down_ff, rep_down_in;

   logic [7:0]               streak_inc;
   logic [7:0]               failed_inc;
   logic [TIME_WIDTH-1:0]    window_diff;
   logic                     window_closed;
   logic                     nack_ignored;
   logic [BACKOFF_WIDTH-1:0] backoff_dbl;
   logic [BACKOFF_WIDTH-1:0] backoff_max;
   logic [BACKOFF_WIDTH-1:0] backoff_clamped;
   logic                     fired;
   logic [2:0]               note;

   assign streak_inc   = (streak_ff == COUNT_MAX) ? streak_ff : streak_ff + 8'd1;
   assign failed_inc   = (failed_ff == COUNT_MAX) ? failed_ff : failed_ff + 8'd1;
   assign window_diff  = evt.now_ms - window_ff;
   assign window_closed = (window_ff != '0) && window_diff[TIME_WIDTH-1];
   assign nack_ignored = ((evt.error_code == ERR_NACK_ADDR) ||
                          (evt.error_code == ERR_NACK_DATA)) && evt.lines_high;
   assign backoff_dbl  = {backoff_ff[BACKOFF_WIDTH-2:0], 1'b0};
   assign backoff_max  = BACKOFF_WIDTH'(cfg.max_interval_ms);
   assign backoff_clamped = (backoff_dbl > backoff_max) ? backoff_max : backoff_dbl;

   always_comb begin
      streak_in   = streak_ff;
      last_err_in = last_err_ff;
      window_in   = window_ff;
      backoff_in  = backoff_ff;
      failed_in   = failed_ff;
      given_up_in = given_up_ff;
      rep_down_in = rep_down_ff;
      fired       = 1'b0;
      note        = NOTICE_NONE;
      case (evt.func)
         FUNC_FAILURE: begin
            last_err_in = evt.error_code;
            if (!nack_ignored) begin
               if (streak_inc < cfg.streak_threshold) begin
                  streak_in = streak_inc;
               end else begin
                  streak_in = '0;
                  if (!given_up_ff && !window_closed) begin
                     if (evt.lines_high) begin
                        window_in = evt.now_ms + TIME_WIDTH'(cfg.max_interval_ms);
                     end else if (evt.clear_released) begin
                        fired      = 1'b1;
                        failed_in  = '0;
                        backoff_in = BACKOFF_WIDTH'(cfg.min_interval_ms);
                        window_in  = evt.now_ms + TIME_WIDTH'(cfg.min_interval_ms);
                        if (rep_down_ff) begin
                           rep_down_in = 1'b0;
                           note        = NOTICE_RECOVERED;
                        end
                     end else begin
                        fired       = 1'b1;
                        rep_down_in = 1'b1;
                        failed_in   = failed_inc;
                        backoff_in  = backoff_clamped;
                        window_in   = evt.now_ms + TIME_WIDTH'(backoff_clamped);
                        if (!rep_down_ff) begin
                           note = NOTICE_HELD_LOW;
                        end
                        if (failed_inc >= cfg.give_up_after) begin
                           given_up_in = 1'b1;
                           note = rep_down_ff ? NOTICE_GAVE_UP : NOTICE_HELD_GAVE_UP;
                        end
                     end
                  end
               end
            end
         end
         FUNC_SUCCESS: begin
            streak_in   = '0;
            failed_in   = '0;
            backoff_in  = BACKOFF_WIDTH'(cfg.min_interval_ms);
            window_in   = '0;
            last_err_in = '0;
            if (given_up_ff || rep_down_ff) begin
               given_up_in = 1'b0;
               rep_down_in = 1'b0;
               note        = NOTICE_BACK;
            end
         end
         FUNC_RETRY: begin
            streak_in   = '0;
            failed_in   = '0;
            backoff_in  = BACKOFF_WIDTH'(cfg.min_interval_ms);
            window_in   = '0;
            given_up_in = 1'b0;
            rep_down_in = 1'b0;
            fired       = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         streak_ff   <= '0;
         last_err_ff <= '0;
         window_ff   <= '0;
         backoff_ff  <= BACKOFF_WIDTH'(RST_MIN_INTERVAL);
         failed_ff   <= '0;
         given_up_ff <= 1'b0;
         rep_down_ff <= 1'b0;
      end else if (advance) begin
         streak_ff   <= streak_in;
         last_err_ff <= last_err_in;
         window_ff   <= window_in;
         backoff_ff  <= backoff_in;
         failed_ff   <= failed_in;
         given_up_ff <= given_up_in;
         rep_down_ff <= rep_down_in;
      end
   end

   assign rsp.recovery_fired = fired;
   assign rsp.bus_down       = given_up_in;
   assign rsp.last_error     = last_err_in;
   assign rsp.notice         = note;

`ifndef SYNTH
   a_fire_clears_streak: assert property (@(posedge clock) disable iff (reset)
      (advance && fired) |=> (streak_ff == '0))
      else $error("streak not cleared after a bus clear");

   a_gave_up_sets_down: assert property (@(posedge clock) disable iff (reset)
      (advance && (note == NOTICE_GAVE_UP || note == NOTICE_HELD_GAVE_UP))
      |=> (given_up_ff && rep_down_ff))
      else $error("give-up notice without bus down");

   a_success_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && evt.func == FUNC_SUCCESS)
      |=> (!given_up_ff && !rep_down_ff && last_err_ff == '0 && window_ff == '0))
      else $error("success left recovery state behind");

   a_backoff_ceiling: assert property (@(posedge clock) disable iff (reset)
      (advance && fired && evt.func == FUNC_FAILURE && !evt.clear_released)
      |=> (backoff_ff <= BACKOFF_WIDTH'(cfg.max_interval_ms)))
      else $error("backoff above ceiling after failed clear");
`endif

endmodule
